// File: rtl/bxpd_pkg.sv
// ----------------------------------------------------------------------------
// bxpd_pkg: shared constants of the XNOR-popcount dot unit
// Field widths, the register map and the column mask function.
// ----------------------------------------------------------------------------
package bxpd_pkg;

  localparam int WORD_BITS        = 64;
  localparam int COLS_W           = 13;
  localparam int BLK_W            = 7;
  localparam int DOT_W            = 14;
  localparam int CNT_W            = 7;
  localparam int IN_TDATA_W       = 2 * WORD_BITS;
  localparam int OUT_TDATA_W      = ((DOT_W + 7) / 8) * 8;
  localparam int APB_DATA_W       = 32;
  localparam int APB_ADDR_W       = 3;
  localparam int MAX_COLS_DEFAULT = 4096;

  localparam logic [COLS_W-1:0] NUM_COLS_RESET  = COLS_W'(64);
  localparam logic [COLS_W-1:0] EQUAL_MAX       = '1;
  localparam logic [BLK_W-1:0]  BLOCK_INDEX_MAX = '1;

  // register index, taken from paddr[2]
  localparam logic REG_NUM_COLS = 1'b0;

  // Bits of word blk whose column (64*blk + bit) lies below cols.
  function automatic logic [WORD_BITS-1:0] column_mask(
    input logic [BLK_W-1:0]  blk,
    input logic [COLS_W-1:0] cols
  );
    logic [COLS_W-1:0] start;
    logic [COLS_W-1:0] left;
    logic [WORD_BITS-1:0] mask;
    start = {blk, 6'b0};
    left  = cols - start;
    if (start >= cols) begin
      mask = '0;
    end else if (left >= COLS_W'(WORD_BITS)) begin
      mask = '1;
    end else begin
      mask = ~({WORD_BITS{1'b1}} << left[5:0]);
    end
    return mask;
  endfunction

endpackage

// File: rtl/binary_xnor_popcount_dot_unit.sv
// ----------------------------------------------------------------------------
// binary_xnor_popcount_dot_unit
// Dot product of two +1/-1 rows packed as bits, one 64-bit word pair a transfer.
// ----------------------------------------------------------------------------
// Usage:
//   s_* stream: tdata = {rhs_word, lhs_word}, tlast marks the last word pair
//   of a row pair. Words are sent in column order, word 0 first.
//   m_* stream: one transfer per row pair, tdata[13:0] = dot (signed),
//   dot = 2*equal_bits - num_cols. Columns at or above num_cols are ignored.
//   APB: register num_cols at address 0, write it only while the unit is idle.
// Throughput: one word pair per cycle while s_tready is high. The popcount,
//   accumulate and dot arithmetic sit between the input register and the
//   result register, so a result follows its tlast transfer through both.
// Stall: while a result waits on m_tready the input register keeps taking
//   non-last words; a further last word waits in the input register and
//   s_tready drops until the result register frees.
// Reset: both stream stages empty, count and word index cleared,
//   num_cols = 64.
// ----------------------------------------------------------------------------
module binary_xnor_popcount_dot_unit #(
  parameter int MAX_COLS = bxpd_pkg::MAX_COLS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  // {rhs_word[127:64], lhs_word[63:0]}
  input  logic [bxpd_pkg::IN_TDATA_W-1:0]    s_tdata,
  input  logic                               s_tlast,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // {zero pad[15:14], dot[13:0]}
  output logic [bxpd_pkg::OUT_TDATA_W-1:0]   m_tdata,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [bxpd_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [bxpd_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [bxpd_pkg::APB_DATA_W-1:0]    prdata,
  output logic                               pready
);

  localparam int WB = bxpd_pkg::WORD_BITS;
  localparam int CW = bxpd_pkg::COLS_W;

  logic [CW-1:0]               num_cols;
  logic [CW-1:0]               cols_wr;
  logic                        cfg_wr;

  logic                        in_valid;
  logic [WB-1:0]               in_lhs;
  logic [WB-1:0]               in_rhs;
  logic                        in_last;

  logic [CW-1:0]               equal_count;
  logic [CW-1:0]               equal_count_next;
  logic [bxpd_pkg::BLK_W-1:0]  block_index;
  logic [bxpd_pkg::BLK_W-1:0]  block_index_next;

  logic                        out_valid;
  logic [bxpd_pkg::DOT_W-1:0]  dot;
  logic [bxpd_pkg::DOT_W-1:0]  dot_next;

  logic [WB-1:0]               same;
  logic [1:0]                  pc2  [WB/2];
  logic [2:0]                  pc4  [WB/4];
  logic [3:0]                  pc8  [WB/8];
  logic [4:0]                  pc16 [WB/16];
  logic [5:0]                  pc32 [WB/32];
  logic [bxpd_pkg::CNT_W-1:0]  ones;
  logic [CW:0]                 sum;
  logic                        advance;
  logic                        s_xfer;

  // ---------------- configuration ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == bxpd_pkg::REG_NUM_COLS);

  always_comb begin
    if (int'(pwdata[CW-1:0]) > MAX_COLS) begin
      cols_wr = CW'(MAX_COLS);
    end else begin
      cols_wr = pwdata[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_cols <= bxpd_pkg::NUM_COLS_RESET;
    end else if (cfg_wr) begin
      num_cols <= cols_wr;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == bxpd_pkg::REG_NUM_COLS) begin
      prdata = bxpd_pkg::APB_DATA_W'(num_cols);
    end
  end

  // ---------------- stream control ----------------
  // a non-last word never needs the result register
  assign advance  = in_valid && (!in_last || !out_valid || m_tready);
  assign s_tready = !in_valid || advance;
  assign s_xfer   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_xfer) begin
      in_lhs  <= s_tdata[WB-1:0];
      in_rhs  <= s_tdata[2*WB-1:WB];
      in_last <= s_tlast;
    end
  end

  // ---------------- popcount and accumulate ----------------
  always_comb begin
    same = ~(in_lhs ^ in_rhs) & bxpd_pkg::column_mask(block_index, num_cols);
    // adder tree popcount, six levels
    for (int i = 0; i < WB/2; i++) begin
      pc2[i] = {1'b0, same[2*i]} + {1'b0, same[2*i+1]};
    end
    for (int i = 0; i < WB/4; i++) begin
      pc4[i] = {1'b0, pc2[2*i]} + {1'b0, pc2[2*i+1]};
    end
    for (int i = 0; i < WB/8; i++) begin
      pc8[i] = {1'b0, pc4[2*i]} + {1'b0, pc4[2*i+1]};
    end
    for (int i = 0; i < WB/16; i++) begin
      pc16[i] = {1'b0, pc8[2*i]} + {1'b0, pc8[2*i+1]};
    end
    for (int i = 0; i < WB/32; i++) begin
      pc32[i] = {1'b0, pc16[2*i]} + {1'b0, pc16[2*i+1]};
    end
    ones = {1'b0, pc32[0]} + {1'b0, pc32[1]};
    sum = {1'b0, equal_count} + (CW+1)'(ones);
    if (sum > {1'b0, bxpd_pkg::EQUAL_MAX}) begin
      equal_count_next = bxpd_pkg::EQUAL_MAX;
    end else begin
      equal_count_next = sum[CW-1:0];
    end
    if (block_index != bxpd_pkg::BLOCK_INDEX_MAX) begin
      block_index_next = block_index + 1'b1;
    end else begin
      block_index_next = block_index;
    end
    dot_next = bxpd_pkg::DOT_W'({equal_count_next, 1'b0} - {1'b0, num_cols});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      equal_count <= '0;
      block_index <= '0;
    end else if (advance) begin
      if (in_last) begin
        equal_count <= '0;
        block_index <= '0;
      end else begin
        equal_count <= equal_count_next;
        block_index <= block_index_next;
      end
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && in_last) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_last) begin
      dot <= dot_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = bxpd_pkg::OUT_TDATA_W'(dot);

endmodule

// File: rtl/bxpd_checker.sv
// ----------------------------------------------------------------------------
// bxpd_checker: port-level checks of the XNOR-popcount dot unit
// Bound to the top level; watches the streams and the APB port only.
// ----------------------------------------------------------------------------
module bxpd_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_tvalid,
  input logic                              s_tready,
  input logic                              s_tlast,
  input logic [bxpd_pkg::OUT_TDATA_W-1:0]  m_tdata,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic                              pready
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result valid right after reset");

  // a fresh result follows a last-word transfer through the input register and the result register
  a_result_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast && !rst, 2))
    else $error("result without a last-word transfer");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[bxpd_pkg::OUT_TDATA_W-1:bxpd_pkg::DOT_W] == '0))
    else $error("tdata padding not zero");

  a_pready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready low");

endmodule

bind binary_xnor_popcount_dot_unit bxpd_checker u_bxpd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tlast  (s_tlast),
  .m_tdata  (m_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .pready   (pready)
);

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the XNOR-popcount dot unit
// Streams word pairs into the unit, predicts each row-pair dot product from a
// local model of the count, word index and column register, and checks every
// result transfer in order. Column settings are changed over APB between
// phases. Both stream sides idle at random, and the receiver holds off once
// for a long stretch.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int WORD_BITS   = bxpd_pkg::WORD_BITS;
  localparam int COLS_W      = bxpd_pkg::COLS_W;
  localparam int BLK_W       = bxpd_pkg::BLK_W;
  localparam int DOT_W       = bxpd_pkg::DOT_W;
  localparam int IN_TDATA_W  = bxpd_pkg::IN_TDATA_W;
  localparam int OUT_TDATA_W = bxpd_pkg::OUT_TDATA_W;
  localparam int APB_DATA_W  = bxpd_pkg::APB_DATA_W;
  localparam int APB_ADDR_W  = bxpd_pkg::APB_ADDR_W;

  localparam int MAX_COLS      = bxpd_pkg::MAX_COLS_DEFAULT;
  localparam int EQUAL_LIMIT   = (1 << COLS_W) - 1;
  localparam int LAST_WORD_POS = (1 << BLK_W) - 1;
  localparam int HOLD_CYCLES   = 300;
  localparam int QUIET_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_CYCLES  = 8;

  localparam logic [APB_ADDR_W-1:0] ADDR_NUM_COLS = {bxpd_pkg::REG_NUM_COLS, 2'b00};
  localparam logic [APB_ADDR_W-1:0] ADDR_UNMAPPED = {~bxpd_pkg::REG_NUM_COLS, 2'b00};

  typedef enum int {
    ROW_RANDOM,
    ROW_EQUAL,
    ROW_OPPOSITE,
    ROW_MIXED
  } row_style_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic [IN_TDATA_W-1:0]  s_tdata  = '0;
  logic                   s_tlast  = 1'b0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic                   psel     = 1'b0;
  logic                   penable  = 1'b0;
  logic                   pwrite   = 1'b0;
  logic [APB_ADDR_W-1:0]  paddr    = '0;
  logic [APB_DATA_W-1:0]  pwdata   = '0;
  logic [APB_DATA_W-1:0]  prdata;
  logic                   pready;

  binary_xnor_popcount_dot_unit #(
    .MAX_COLS(MAX_COLS)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tdata (s_tdata),
    .s_tlast (s_tlast),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tdata (m_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // local copy of the unit's state
  logic [COLS_W-1:0] model_cols = bxpd_pkg::NUM_COLS_RESET;
  int                row_equal  = 0;
  int                word_pos   = 0;

  logic signed [DOT_W-1:0] pending_dots[$];
  logic signed [DOT_W-1:0] want_dot;

  int errors      = 0;
  int items_sent  = 0;
  int src_idle_pct = 0;
  int snk_idle_pct = 0;

  int hold_req  = 0;
  int hold_ack  = 0;
  int hold_left = 0;
  int quiet     = 0;

  // one word pair into the running row count
  function automatic void accumulate_pair(input logic [WORD_BITS-1:0] lhs,
                                          input logic [WORD_BITS-1:0] rhs,
                                          input logic is_last);
    logic [WORD_BITS-1:0] keep;
    int sum;
    int dot;
    for (int i = 0; i < WORD_BITS; i++) begin
      keep[i] = (word_pos * WORD_BITS + i) < int'(model_cols);
    end
    sum = row_equal + $countones(~(lhs ^ rhs) & keep);
    if (sum > EQUAL_LIMIT) sum = EQUAL_LIMIT;
    row_equal = sum;
    if (word_pos < LAST_WORD_POS) word_pos++;
    if (is_last) begin
      dot = 2 * row_equal - int'(model_cols);
      pending_dots.push_back(dot[DOT_W-1:0]);
      row_equal = 0;
      word_pos  = 0;
    end
  endfunction

  function automatic void store_cols(input logic [APB_ADDR_W-1:0] addr,
                                     input logic [APB_DATA_W-1:0] data);
    int v;
    if (addr != ADDR_NUM_COLS) return;
    v = int'(data[COLS_W-1:0]);
    if (v > MAX_COLS) v = MAX_COLS;
    model_cols = COLS_W'(v);
  endfunction

  function automatic int words_for(input int cols);
    return (cols + WORD_BITS - 1) / WORD_BITS > 0 ? (cols + WORD_BITS - 1) / WORD_BITS : 1;
  endfunction

  function automatic logic [WORD_BITS-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  task automatic send_pair(input logic [WORD_BITS-1:0] lhs,
                           input logic [WORD_BITS-1:0] rhs,
                           input logic is_last);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tdata  <= {rhs, lhs};
    s_tlast  <= is_last;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    accumulate_pair(lhs, rhs, is_last);
    items_sent++;
  endtask

  task automatic send_row(input int words, input row_style_t style);
    logic [WORD_BITS-1:0] lhs;
    logic [WORD_BITS-1:0] rhs;
    for (int w = 0; w < words; w++) begin
      lhs = rand_word();
      case (style)
        ROW_EQUAL:    rhs = lhs;
        ROW_OPPOSITE: rhs = ~lhs;
        ROW_MIXED: begin
          case ($urandom_range(3))
            0: rhs = lhs;
            1: rhs = ~lhs;
            2: rhs = '0;
            default: rhs = '1;
          endcase
        end
        default: rhs = rand_word();
      endcase
      send_pair(lhs, rhs, w == words - 1);
    end
  endtask

  // nothing in flight, inputs quiet, pipeline settled
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_dots.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input logic [APB_ADDR_W-1:0] addr,
                           input logic [APB_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    store_cols(addr, data);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apb_check_cols();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_NUM_COLS;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== APB_DATA_W'(model_cols)) begin
      $display("%0t: num_cols read expected %0d got %0d", $time, model_cols, prdata);
      errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_cols(input int cols);
    apb_write(ADDR_NUM_COLS, APB_DATA_W'(cols));
  endtask

  // ---- tests ----

  task automatic test_reset_state();
    apb_check_cols();
    send_row(1, ROW_EQUAL);
    send_row(1, ROW_OPPOSITE);
    send_row(1, ROW_RANDOM);
    wait_idle();
  endtask

  task automatic test_column_edges();
    set_cols(1);
    send_pair('0, '0, 1'b1);
    send_pair(64'h1, '0, 1'b1);
    send_pair(~64'h1, '0, 1'b1);
    wait_idle();
    set_cols(65);
    send_row(2, ROW_EQUAL);
    send_pair('1, '0, 1'b0);
    send_pair(64'h1, 64'h1, 1'b1);
    wait_idle();
    // no columns at all: every word is masked away
    set_cols(0);
    send_row(1, ROW_EQUAL);
    send_row(2, ROW_RANDOM);
    wait_idle();
    // words past the last column add nothing
    set_cols(64);
    send_row(3, ROW_EQUAL);
    wait_idle();
    set_cols(100);
    send_row(2, ROW_RANDOM);
    send_row(4, ROW_OPPOSITE);
    wait_idle();
  endtask

  task automatic test_register_map();
    set_cols(8191);
    apb_check_cols();
    apb_write(ADDR_UNMAPPED, 32'd5);
    apb_check_cols();
    apb_write(ADDR_NUM_COLS, 32'hFFFF_E000 | 32'd10);
    apb_check_cols();
    send_row(1, ROW_RANDOM);
    wait_idle();
    apb_write(ADDR_NUM_COLS, 32'h0000_1001);
    apb_check_cols();
    send_row(1, ROW_EQUAL);
    wait_idle();
  endtask

  // rows longer than the word index can count, at the full column range
  task automatic test_index_saturation();
    set_cols(MAX_COLS);
    send_row(LAST_WORD_POS + 3, ROW_EQUAL);
    send_row(MAX_COLS / WORD_BITS, ROW_OPPOSITE);
    wait_idle();
  endtask

  function automatic int pick_cols();
    int r;
    r = $urandom_range(99);
    if (r < 60) return $urandom_range(1, 200);
    if (r < 70) return $urandom_range(201, 700);
    if (r < 76) return MAX_COLS;
    if (r < 84) begin
      case ($urandom_range(5))
        0: return 1;
        1: return 63;
        2: return 64;
        3: return 65;
        4: return 128;
        default: return 129;
      endcase
    end
    if (r < 88) return 0;
    if (r < 94) return $urandom_range(MAX_COLS + 1, EQUAL_LIMIT);
    return $urandom_range(0, MAX_COLS);
  endfunction

  task automatic test_random(input int n_items, input int src_pct, input int snk_pct);
    int start;
    int rows_left;
    int words;
    row_style_t style;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    start = items_sent;
    rows_left = 0;
    while (items_sent - start < n_items) begin
      if (rows_left == 0) begin
        wait_idle();
        // high pwdata bits sometimes set; the register takes its low bits, clamped to MAX_COLS
        if ($urandom_range(3) == 0)
          apb_write(ADDR_NUM_COLS,
                    {$urandom} & ~APB_DATA_W'(EQUAL_LIMIT) | APB_DATA_W'(pick_cols()));
        else
          set_cols(pick_cols());
        rows_left = words_for(int'(model_cols)) > 16 ? 1 : $urandom_range(3, 10);
      end
      words = words_for(int'(model_cols));
      // broken rows: short or overlong
      if ($urandom_range(99) < 15) words = $urandom_range(1, words + 3);
      case ($urandom_range(9))
        0:       style = ROW_EQUAL;
        1:       style = ROW_OPPOSITE;
        2:       style = ROW_MIXED;
        default: style = ROW_RANDOM;
      endcase
      send_row(words, style);
      rows_left--;
    end
    wait_idle();
  endtask

  // receiver stalls long enough for the unit to back up its input
  task automatic test_backpressure();
    src_idle_pct = 0;
    snk_idle_pct = 0;
    set_cols(70);
    hold_req <= hold_req + 1;
    for (int r = 0; r < 12; r++) begin
      send_row(1, ROW_RANDOM);
      send_row(2, ROW_MIXED);
    end
    wait_idle();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    src_idle_pct = 30;
    snk_idle_pct = 53;
    test_reset_state();
    test_column_edges();
    test_register_map();
    test_index_saturation();
    test_random(60, 30, 53);
    test_random(60, 53, 30);
    test_random(60, 0, 0);
    test_backpressure();
    s_tvalid <= 1'b0;
    while (pending_dots.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  // result check and receiver ready
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_dots.size() == 0) begin
        $display("%0t: unexpected result transfer, dot %0d", $time,
                 $signed(m_tdata[DOT_W-1:0]));
        errors++;
      end else begin
        want_dot = pending_dots.pop_front();
        if (m_tdata[DOT_W-1:0] !== want_dot) begin
          $display("%0t: dot expected %0d got %0d", $time, want_dot,
                   $signed(m_tdata[DOT_W-1:0]));
          errors++;
        end
      end
    end
    if (hold_left != 0 || hold_req != hold_ack) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(99) >= snk_idle_pct);
  end

  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_left <= HOLD_CYCLES;
      hold_ack  <= hold_req;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (psel && penable && pready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, quiet);
      $display("tb_top: errors");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

endmodule
